FILE: rtl/core/kbq_pkg.sv
// Shared types and constants for the keyboard command queue.
`timescale 1ns / 1ps
package kbq_pkg;

	localparam int unsigned RING_SLOTS_DEF = 16;

	localparam logic [7:0] RESP_ACK    = 8'hFA;
	localparam logic [7:0] RESP_RESEND = 8'hFE;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_RX   = 1'b1;

	localparam logic [1:0] CNT_MAX = 2'd2;

	// One stored command.
	typedef struct packed {
		logic [7:0] data_second;
		logic [7:0] data_first;
		logic [1:0] data_count;
		logic [7:0] command_byte;
	} entry_t;

	// One input word.
	typedef struct packed {
		logic       kind;
		logic [7:0] command_byte;
		logic [1:0] data_count;
		logic [7:0] data_first;
		logic [7:0] data_second;
		logic [7:0] rx_byte;
	} item_t;

	// One result word.
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       scancode_valid;
		logic [7:0] scancode;
		logic       overflow;
		logic       halted;
		logic [3:0] pending_count;
		logic       last;
	} result_t;

	// What the evaluated item leads to.
	typedef enum logic [1:0] {
		ACT_SINGLE    = 2'd0,
		ACT_SEND_NOW  = 2'd1,
		ACT_SEND_READ = 2'd2
	} action_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_entry;
		logic send_byte;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		action_t act;
		logic    out_free;
		logic    last_byte;
	} dp_status_t;

endpackage

FILE: rtl/core/kbq_item_if.sv
// Input channel: command pushes and received keyboard bytes.
`timescale 1ns / 1ps
interface kbq_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] command_byte;
	logic [1:0] data_count;
	logic [7:0] data_first;
	logic [7:0] data_second;
	logic [7:0] rx_byte;

	modport source (output valid, kind, command_byte, data_count, data_first, data_second,
		rx_byte, input ready);
	modport sink (input valid, kind, command_byte, data_count, data_first, data_second,
		rx_byte, output ready);
endinterface

FILE: rtl/core/kbq_result_if.sv
// Result channel: transmit bytes, scancodes and status.
`timescale 1ns / 1ps
interface kbq_result_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       scancode_valid;
	logic [7:0] scancode;
	logic       overflow;
	logic       halted;
	logic [3:0] pending_count;
	logic       last;

	modport source (output valid, tx_valid, tx_byte, scancode_valid, scancode, overflow,
		halted, pending_count, last, input ready);
	modport sink (input valid, tx_valid, tx_byte, scancode_valid, scancode, overflow,
		halted, pending_count, last, output ready);
endinterface

FILE: rtl/core/kbq_ctrl.sv
// Sequencing state machine for the keyboard command queue.
`timescale 1ns / 1ps
module kbq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  kbq_pkg::dp_status_t    sts,
	output kbq_pkg::ctrl_cmd_t     cmd
);
	import kbq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_READ = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// hold until the output register can take a word
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					unique case (sts.act)
						ACT_SEND_NOW:  state_d = ST_SEND;
						ACT_SEND_READ: state_d = ST_READ;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				cmd.load_entry = 1'b1;
				state_d        = ST_SEND;
			end
			ST_SEND: begin
				if (sts.out_free) begin
					cmd.send_byte = 1'b1;
					if (sts.last_byte) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/kbq_dp.sv
// Datapath: command ring, pointers, halt flag and output register.
`timescale 1ns / 1ps
module kbq_dp #(
	parameter int unsigned RING_SLOTS = kbq_pkg::RING_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kbq_pkg::item_t       item,
	input  kbq_pkg::ctrl_cmd_t   cmd,
	output kbq_pkg::dp_status_t  sts,
	output kbq_pkg::result_t     res,
	output logic                 res_valid,
	input  logic                 res_ready
);
	import kbq_pkg::*;

	localparam int unsigned IW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_SLOTS - 1);

	entry_t mem [RING_SLOTS];
	entry_t rd_data_q;

	item_t         item_q;
	logic [IW-1:0] head_q, tail_q;
	logic          stopped_q;
	entry_t        entry_q;
	logic [1:0]    idx_q;
	result_t       res_q;
	logic          res_valid_q;

	logic [IW-1:0] head_inc, tail_inc, head_n, tail_n, rd_addr, ph, pt;
	logic          empty, full, stop_n, sc_v, ovf, wr;
	action_t       act;
	logic [IW:0]   pend;
	logic [IW+4:0] pend_ext;
	logic [7:0]    byte_sel;
	entry_t        new_entry;
	item_t         item_sat;

	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign empty    = (head_q == tail_q);
	assign full     = (tail_inc == head_q);

	assign new_entry.command_byte = item_q.command_byte;
	assign new_entry.data_count   = item_q.data_count;
	assign new_entry.data_first   = item_q.data_first;
	assign new_entry.data_second  = item_q.data_second;

	// saturate a data count of three to two
	always_comb begin
		item_sat = item;
		if (item.data_count > CNT_MAX) begin
			item_sat.data_count = CNT_MAX;
		end
	end

	always_comb begin
		act    = ACT_SINGLE;
		head_n = head_q;
		tail_n = tail_q;
		stop_n = stopped_q;
		sc_v   = 1'b0;
		ovf    = 1'b0;
		wr     = 1'b0;
		if (stopped_q) begin
			act = ACT_SINGLE;
		end else if (item_q.kind == KIND_PUSH) begin
			if (full) begin
				ovf = 1'b1;
			end else begin
				wr     = 1'b1;
				tail_n = tail_inc;
				act    = empty ? ACT_SEND_NOW : ACT_SINGLE;
			end
		end else if (empty) begin
			sc_v = 1'b1;
		end else if (item_q.rx_byte == RESP_ACK) begin
			head_n = head_inc;
			if (head_inc != tail_q) begin
				act = ACT_SEND_READ;
			end
		end else if (item_q.rx_byte == RESP_RESEND) begin
			act = ACT_SEND_READ;
		end else begin
			stop_n = 1'b1;
		end
	end

	assign rd_addr = (item_q.rx_byte == RESP_ACK) ? head_inc : head_q;

	// count after the step: next pointers while executing, stored ones otherwise
	assign ph = cmd.exec ? head_n : head_q;
	assign pt = cmd.exec ? tail_n : tail_q;
	always_comb begin
		if (pt >= ph) begin
			pend = {1'b0, pt} - {1'b0, ph};
		end else begin
			pend = {1'b0, pt} + (IW+1)'(RING_SLOTS) - {1'b0, ph};
		end
	end
	assign pend_ext = (IW+5)'(pend);

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = entry_q.command_byte;
			2'd1:    byte_sel = entry_q.data_first;
			default: byte_sel = entry_q.data_second;
		endcase
	end

	assign sts.act       = act;
	assign sts.out_free  = !res_valid_q || res_ready;
	assign sts.last_byte = (idx_q == entry_q.data_count);

	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && wr) begin
			mem[tail_q] <= new_entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_sat;
		end
		if (cmd.exec) begin
			entry_q <= new_entry;
			idx_q   <= 2'd0;
		end else if (cmd.load_entry) begin
			entry_q <= rd_data_q;
			idx_q   <= 2'd0;
		end else if (cmd.send_byte) begin
			idx_q <= idx_q + 2'd1;
		end
		if (cmd.exec && act == ACT_SINGLE) begin
			res_q.tx_valid       <= 1'b0;
			res_q.tx_byte        <= 8'd0;
			res_q.scancode_valid <= sc_v;
			res_q.scancode       <= sc_v ? item_q.rx_byte : 8'd0;
			res_q.overflow       <= ovf;
			res_q.halted         <= stop_n;
			res_q.pending_count  <= pend_ext[3:0];
			res_q.last           <= 1'b1;
		end else if (cmd.send_byte) begin
			res_q.tx_valid       <= 1'b1;
			res_q.tx_byte        <= byte_sel;
			res_q.scancode_valid <= 1'b0;
			res_q.scancode       <= 8'd0;
			res_q.overflow       <= 1'b0;
			res_q.halted         <= stopped_q;
			res_q.pending_count  <= pend_ext[3:0];
			res_q.last           <= (idx_q == entry_q.data_count);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q    <= head_n;
				tail_q    <= tail_n;
				stopped_q <= stop_n;
			end
			if ((cmd.exec && act == ACT_SINGLE) || cmd.send_byte) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/ps2_keyboard_command_queue.sv
// Top level of the PS/2 keyboard command queue.
// Holds up to RING_SLOTS-1 keyboard commands (a command byte and zero to two data bytes)
// and sends the front one until the keyboard acknowledges it with FA; FE resends it, any
// other response halts the block until reset, and with no command pending received bytes
// come out as scancodes. Each input word gives one to three result words, the last one
// flagged. Items are handled one at a time; an acknowledge or resend that sends a stored
// command first passes through the registered read of the command ring. A slow result
// sink stalls the block. The next item is taken while the last result still waits in
// the output register.
`timescale 1ns / 1ps
module ps2_keyboard_command_queue #(
	parameter int unsigned RING_SLOTS = kbq_pkg::RING_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	kbq_item_if.sink     item,
	kbq_result_if.source result
);
	import kbq_pkg::*;

	item_t      item_w;
	result_t    res_w;
	ctrl_cmd_t  cmd_w;
	dp_status_t sts_w;
	logic       res_valid_w;

	assign item_w.kind         = item.kind;
	assign item_w.command_byte = item.command_byte;
	assign item_w.data_count   = item.data_count;
	assign item_w.data_first   = item.data_first;
	assign item_w.data_second  = item.data_second;
	assign item_w.rx_byte      = item.rx_byte;

	kbq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts_w),
		.cmd        (cmd_w)
	);

	kbq_dp #(
		.RING_SLOTS (RING_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_w),
		.cmd       (cmd_w),
		.sts       (sts_w),
		.res       (res_w),
		.res_valid (res_valid_w),
		.res_ready (result.ready)
	);

	assign result.valid          = res_valid_w;
	assign result.tx_valid       = res_w.tx_valid;
	assign result.tx_byte        = res_w.tx_byte;
	assign result.scancode_valid = res_w.scancode_valid;
	assign result.scancode       = res_w.scancode;
	assign result.overflow       = res_w.overflow;
	assign result.halted         = res_w.halted;
	assign result.pending_count  = res_w.pending_count;
	assign result.last           = res_w.last;

endmodule
